>>> sv/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

>>> sv/msi_pkg.sv
// Shared types and constants for the merge sorter.
// No dependencies.
package msi_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_MRG_INIT,
    S_RD_L,
    S_RD_R,
    S_WAIT,
    S_MERGE,
    S_FETCH,
    S_OUT_RD,
    S_OUT_CAP
  } state_e;

endpackage

>>> sv/msi_if.sv
// Valid/ready stream interfaces for the sorter input and output channels.
// Depends on msi_pkg.
interface msi_in_if import msi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface msi_out_if import msi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

>>> sv/msi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module msi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/merge_sort_integers_core.sv
// Streaming merge sorter for sets of signed 32-bit integers.
// Depends on msi_pkg, msi_if (msi_in_if, msi_out_if), msi_ram, assert_macros.svh.
//
// Usage:
//   in_i  : one value per transfer, last_in marks the end of a set. A set is
//           also closed when it reaches SET_SIZE values without the flag.
//   out_o : the closed set in ascending order, one value per transfer,
//           last_out on the final one.
// Phases for a set of N values (P = ceil(log2 N) merge passes):
//   load   : N values, one transfer per cycle while in_i.valid is high.
//   sort   : P passes; each merged element costs a write plus a refill
//            read of the single read port of the source buffer.
//   output : per value, a read, then a capture into the output reg.
// in_i.ready is high only while collecting a set. The next set may start
// loading while the last sorted value still waits in the output register.
// Reset (async, active low) empties the set and drops any pending output;
// the buffers themselves are not cleared. A stalled receiver holds the
// output register and simply pauses the read-out sequence.
`include "assert_macros.svh"

module merge_sort_integers_core import msi_pkg::*; #(
  parameter int unsigned SET_SIZE = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msi_in_if.sink    in_i,
  msi_out_if.source out_o
);

  // Address, count and sum widths.
  localparam int unsigned AW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam int unsigned CW = $clog2(SET_SIZE + 1);
  localparam int unsigned SW = CW + 2;
  localparam logic [CW-1:0] LAST_IDX = CW'(SET_SIZE - 1);

  // Control state.
  state_e        state_q, state_d;
  logic [CW-1:0] fill_q;   // values collected so far
  logic [CW-1:0] n_q;      // size of the closed set
  logic [CW-1:0] w_q;      // run width of the current pass
  logic [CW-1:0] lo_q;     // start of the current run pair
  logic [CW-1:0] mid_q;    // end of left run
  logic [CW-1:0] hi_q;     // end of right run
  logic [CW-1:0] i_q;      // left run read pointer
  logic [CW-1:0] j_q;      // right run read pointer
  logic [CW-1:0] k_q;      // write pointer, reused as read-out pointer
  logic          src_q;    // 0: buffer A holds the runs, 1: buffer B
  logic          took_l_q; // last merge step consumed the left head
  logic          out_valid_q;

  // Datapath registers.
  logic signed [DATA_W-1:0] head_l_q;
  logic signed [DATA_W-1:0] head_r_q;
  logic signed [DATA_W-1:0] out_data_q;
  logic                     out_last_q;

  // Memory ports. Reads always come from the source buffer and merge
  // writes always go to the other one, so no entry is read and written
  // in the same cycle and no forwarding is needed.
  logic              load_we;
  logic              merge_we;
  logic              we_a, we_b;
  logic [CW-1:0]     waddr;
  logic [CW-1:0]     raddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata_a, rdata_b, rdata;

  logic          in_xfer;
  logic          close_set;
  logic          out_free;
  logic          take_l;
  logic          pass_done;
  logic          sort_done;
  logic          out_last;
  logic [CW-1:0] k_nxt;
  logic [SW-1:0] sum_mid, sum_hi, w_dbl;
  logic [CW-1:0] mid_c, hi_c;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign close_set = in_i.last_in || (fill_q == LAST_IDX);
  assign out_free  = !out_valid_q || out_o.ready;

  // Run bounds for the next pair, clamped to the set size.
  assign sum_mid = SW'(lo_q) + SW'(w_q);
  assign sum_hi  = sum_mid + SW'(w_q);
  assign w_dbl   = SW'(w_q) << 1;
  assign mid_c   = (sum_mid >= SW'(n_q)) ? n_q : sum_mid[CW-1:0];
  assign hi_c    = (sum_hi >= SW'(n_q)) ? n_q : sum_hi[CW-1:0];

  assign pass_done = (lo_q >= n_q);
  assign sort_done = (w_dbl >= SW'(n_q));
  assign out_last  = (k_q == (n_q - CW'(1)));
  assign k_nxt     = k_q + CW'(1);

  // Left head wins only when strictly smaller; an exhausted run never wins.
  assign take_l = (i_q < mid_q) && ((j_q >= hi_q) || (head_l_q < head_r_q));

  assign rdata = src_q ? rdata_b : rdata_a;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (in_xfer && close_set) begin
          state_d = (fill_q == '0) ? S_OUT_RD : S_MRG_INIT;
        end
      end
      S_MRG_INIT: begin
        if (pass_done) begin
          state_d = sort_done ? S_OUT_RD : S_MRG_INIT;
        end else begin
          state_d = S_RD_L;
        end
      end
      S_RD_L:  state_d = S_RD_R;
      S_RD_R:  state_d = S_WAIT;
      S_WAIT:  state_d = S_MERGE;
      S_MERGE: state_d = (k_nxt == hi_q) ? S_MRG_INIT : S_FETCH;
      S_FETCH: state_d = S_MERGE;
      S_OUT_RD: begin
        if (out_free) begin
          state_d = S_OUT_CAP;
        end
      end
      S_OUT_CAP: state_d = out_last ? S_LOAD : S_OUT_RD;
      default:   state_d = S_LOAD;
    endcase
  end

  // Memory control.
  always_comb begin
    load_we  = 1'b0;
    merge_we = 1'b0;
    waddr    = k_q;
    wdata    = $unsigned(take_l ? head_l_q : head_r_q);
    raddr    = k_q;
    case (state_q)
      S_LOAD: begin
        load_we = in_xfer;
        waddr   = fill_q;
        wdata   = $unsigned(in_i.value);
      end
      S_RD_L: raddr = i_q;
      S_RD_R: raddr = j_q;
      S_MERGE: begin
        merge_we = 1'b1;
        // Refill the head that is consumed now.
        raddr    = take_l ? (i_q + CW'(1)) : (j_q + CW'(1));
      end
      default: raddr = k_q;
    endcase
  end

  assign we_a = load_we || (merge_we && src_q);
  assign we_b = merge_we && !src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      fill_q      <= '0;
      n_q         <= '0;
      w_q         <= '0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      src_q       <= 1'b0;
      took_l_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == S_OUT_CAP) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_LOAD: begin
          if (in_xfer) begin
            if (close_set) begin
              n_q    <= fill_q + CW'(1);
              fill_q <= '0;
              src_q  <= 1'b0;
              w_q    <= CW'(1);
              lo_q   <= '0;
              k_q    <= '0;
            end else begin
              fill_q <= fill_q + CW'(1);
            end
          end
        end
        S_MRG_INIT: begin
          if (pass_done) begin
            // Runs now live in the buffer just written.
            src_q <= !src_q;
            lo_q  <= '0;
            k_q   <= '0;
            if (!sort_done) begin
              w_q <= w_dbl[CW-1:0];
            end
          end else begin
            mid_q <= mid_c;
            hi_q  <= hi_c;
            i_q   <= lo_q;
            j_q   <= mid_c;
            k_q   <= lo_q;
          end
        end
        S_MERGE: begin
          k_q      <= k_nxt;
          took_l_q <= take_l;
          if (take_l) begin
            i_q <= i_q + CW'(1);
          end else begin
            j_q <= j_q + CW'(1);
          end
          if (k_nxt == hi_q) begin
            lo_q <= hi_q;
          end
        end
        S_OUT_CAP: k_q <= k_nxt;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_RD_R: head_l_q <= $signed(rdata);
      S_WAIT: head_r_q <= $signed(rdata);
      S_FETCH: begin
        if (took_l_q) begin
          head_l_q <= $signed(rdata);
        end else begin
          head_r_q <= $signed(rdata);
        end
      end
      S_OUT_CAP: begin
        out_data_q <= $signed(rdata);
        out_last_q <= out_last;
      end
      default: ;
    endcase
  end

  msi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SET_SIZE)
  ) u_buf_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (rdata_a)
  );

  msi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SET_SIZE)
  ) u_buf_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (rdata_b)
  );

  assign in_i.ready         = (state_q == S_LOAD);
  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_data_q;
  assign out_o.last_out     = out_last_q;

  // Merge writes stay inside the current pair and the closed set.
  `ASSERT_PROP(a_merge_bounds, clk_i, rst_ni, (state_q == S_MERGE) |-> ((k_q < hi_q) && (hi_q <= n_q)), "merge write out of range")
  // A merge step always has an element left in one of the runs.
  `ASSERT_PROP(a_merge_src, clk_i, rst_ni, (state_q == S_MERGE) |-> ((i_q < mid_q) || (j_q < hi_q)), "merge from exhausted runs")
  // The output register is never overwritten while a value waits in it.
  `ASSERT_NEVER(a_out_overwrite, clk_i, rst_ni, (state_q == S_OUT_CAP) && out_valid_q, "output overwritten")

endmodule
